// ----- rtl/core/bayer_bilinear_demosaic_core_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the Bayer demosaic core
// Implication checks on the core's own control and result logic.
// ----------------------------------------------------------------------------
`ifndef BAYER_BILINEAR_DEMOSAIC_CORE_ASSERT_SVH
`define BAYER_BILINEAR_DEMOSAIC_CORE_ASSERT_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define BBD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bbd assertion failed");
// next-cycle implication
`define BBD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bbd assertion failed");
`else
`define BBD_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define BBD_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ----- rtl/core/bbd_pkg.sv -----
// ----------------------------------------------------------------------------
// bbd_pkg
// Types and constants shared by the Bayer demosaic core.
// ----------------------------------------------------------------------------
package bbd_pkg;

  localparam int MAX_WIDTH_DEF  = 2048;
  localparam int MAX_HEIGHT_DEF = 4096;
  localparam int PIXEL_BITS_DEF = 16;

  localparam int PORT_PIX_W   = 16;
  localparam int WIDTH_REG_W  = 12;
  localparam int HEIGHT_REG_W = 13;
  localparam int CFG_DATA_W   = 13;
  localparam int CFG_INDEX_W  = 3;

  localparam logic [WIDTH_REG_W-1:0]  WIDTH_RST  = 12'd640;
  localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RST = 13'd480;

  // smallest frame side; sizes below are clamped up to it
  localparam int DIM_MIN = 5;
  // window centre columns/rows below this (input position) are border
  localparam int EDGE_LO = 3;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_WIDTH   = 3'd0,
    REG_HEIGHT  = 3'd1,
    REG_X_PHASE = 3'd2,
    REG_Y_PHASE = 3'd3
  } cfg_reg_t;

  // control travelling with an item from the input register to the result
  typedef struct packed {
    logic has_result;
    logic border;
    logic px;
    logic py;
    logic frame_end;
  } s1_ctrl_t;

endpackage

// ----- rtl/core/bbd_ram.sv -----
// ----------------------------------------------------------------------------
// bbd_ram
// Simple dual-port RAM: one write port, one enabled read port, registered read.
// ----------------------------------------------------------------------------
module bbd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/core/bayer_bilinear_demosaic_core.sv -----
// ----------------------------------------------------------------------------
// bayer_bilinear_demosaic_core
// Streaming bilinear demosaic over a 3x3 window fed by two line RAMs.
//
//   channel | direction | handshake         | payload
//   in_     | input     | in_valid/in_ready | in_raw_pixel
//   out_    | output    | out_valid/out_ready | out_red/green/blue/border/frame_end
//   cfg_    | input     | cfg_we            | cfg_index, cfg_wdata
//
// One item per clock while the output does not stall; an accepted item passes
// the stage 1 register and, with a result, the result register. Stage 0 issues the
// line RAM reads, stage 1 shifts the window, writes the RAMs back and registers
// the RGB result. Reset is synchronous and clears control, counters and window,
// not the RAMs. An output stall holds stage 1 only once its result cannot move.
// ----------------------------------------------------------------------------
`include "bayer_bilinear_demosaic_core_assert.svh"

module bayer_bilinear_demosaic_core #(
  parameter int MAX_WIDTH  = bbd_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = bbd_pkg::MAX_HEIGHT_DEF,
  parameter int PIXEL_BITS = bbd_pkg::PIXEL_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [bbd_pkg::PORT_PIX_W-1:0]   in_raw_pixel,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [bbd_pkg::PORT_PIX_W-1:0]   out_red,
  output logic [bbd_pkg::PORT_PIX_W-1:0]   out_green,
  output logic [bbd_pkg::PORT_PIX_W-1:0]   out_blue,
  output logic                             out_border,
  output logic                             out_frame_end,
  input  logic                             cfg_we,
  input  logic [bbd_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [bbd_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  import bbd_pkg::*;

  localparam int XW = $clog2(MAX_WIDTH);
  localparam int YW = $clog2(MAX_HEIGHT);
  localparam int PB = PIXEL_BITS;

  // configuration
  logic [WIDTH_REG_W-1:0]  width_r;
  logic [HEIGHT_REG_W-1:0] height_r;
  logic                    xph_r;
  logic                    yph_r;

  // stage 0 position
  logic [XW-1:0] col_r;
  logic [YW-1:0] row_r;

  // stage 1
  logic          v1_r;
  s1_ctrl_t      c1_r;
  s1_ctrl_t      c1_nxt;
  logic [XW-1:0] x1_r;
  logic [PB-1:0] pix1_r;

  logic [PB-1:0] win_r   [3][3];
  logic [PB-1:0] win_nxt [3][3];
  logic [PB-1:0] rd_a;
  logic [PB-1:0] rd_b;

  // result register
  logic                  out_valid_r;
  logic [PORT_PIX_W-1:0] red_r;
  logic [PORT_PIX_W-1:0] green_r;
  logic [PORT_PIX_W-1:0] blue_r;
  logic                  border_r;
  logic                  fend_r;

  logic [XW:0] w_lim;
  logic [YW:0] h_lim;
  logic        last_col;
  logic        last_row;
  logic        in_acc;
  logic        out_free;
  logic        s1_go;

  logic [PB:0]   hz_sum;
  logic [PB:0]   vt_sum;
  logic [PB+1:0] dg_sum;
  logic [PB+1:0] cr_sum;
  logic [PB-1:0] ctr;
  logic [PB-1:0] red_nxt;
  logic [PB-1:0] green_nxt;
  logic [PB-1:0] blue_nxt;

  // ---------------- configuration ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
      xph_r    <= 1'b0;
      yph_r    <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_WIDTH:   width_r  <= cfg_wdata[WIDTH_REG_W-1:0];
        REG_HEIGHT:  height_r <= cfg_wdata[HEIGHT_REG_W-1:0];
        REG_X_PHASE: xph_r    <= cfg_wdata[0];
        REG_Y_PHASE: yph_r    <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (32'(width_r) < 32'(DIM_MIN)) begin
      w_lim = (XW+1)'(DIM_MIN);
    end else if (32'(width_r) > 32'(MAX_WIDTH)) begin
      w_lim = (XW+1)'(MAX_WIDTH);
    end else begin
      w_lim = (XW+1)'(width_r);
    end
    if (32'(height_r) < 32'(DIM_MIN)) begin
      h_lim = (YW+1)'(DIM_MIN);
    end else if (32'(height_r) > 32'(MAX_HEIGHT)) begin
      h_lim = (YW+1)'(MAX_HEIGHT);
    end else begin
      h_lim = (YW+1)'(height_r);
    end
  end

  // ---------------- handshake ----------------
  assign out_free = !out_valid_r || out_ready;
  assign s1_go    = v1_r && (!c1_r.has_result || out_free);
  assign in_ready = !v1_r || s1_go;
  assign in_acc   = in_valid && in_ready;

  // ---------------- stage 0 ----------------
  assign last_col = {1'b0, col_r} >= (w_lim - (XW+1)'(1));
  assign last_row = {1'b0, row_r} >= (h_lim - (YW+1)'(1));

  always_comb begin
    c1_nxt.has_result = (col_r != '0) && (row_r != '0);
    // centre is one column/row back, so its far-edge test equals last_col/last_row
    c1_nxt.border     = (col_r < XW'(EDGE_LO)) || last_col ||
                        (row_r < YW'(EDGE_LO)) || last_row;
    c1_nxt.px         = ~col_r[0] ^ xph_r;
    c1_nxt.py         = ~row_r[0] ^ yph_r;
    c1_nxt.frame_end  = last_col && last_row;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      v1_r  <= 1'b0;
      c1_r  <= '0;
    end else begin
      if (in_acc) begin
        if (last_col) begin
          col_r <= '0;
          row_r <= last_row ? '0 : row_r + YW'(1);
        end else begin
          col_r <= col_r + XW'(1);
        end
        c1_r <= c1_nxt;
      end
      if (in_acc) begin
        v1_r <= 1'b1;
      end else if (s1_go) begin
        v1_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      x1_r   <= col_r;
      pix1_r <= in_raw_pixel[PB-1:0];
    end
  end

  // line RAMs: a holds row y-1, b holds row y-2
  bbd_ram #(.WIDTH(PB), .DEPTH(MAX_WIDTH)) u_line_a (
    .clk   (clk),
    .we    (s1_go),
    .waddr (x1_r),
    .wdata (pix1_r),
    .re    (in_acc),
    .raddr (col_r),
    .rdata (rd_a)
  );

  bbd_ram #(.WIDTH(PB), .DEPTH(MAX_WIDTH)) u_line_b (
    .clk   (clk),
    .we    (s1_go),
    .waddr (x1_r),
    .wdata (rd_a),
    .re    (in_acc),
    .raddr (col_r),
    .rdata (rd_b)
  );

  // ---------------- stage 1 ----------------
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win_nxt[r][0] = win_r[r][1];
      win_nxt[r][1] = win_r[r][2];
    end
    win_nxt[0][2] = rd_b;
    win_nxt[1][2] = rd_a;
    win_nxt[2][2] = pix1_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win_r[r][c] <= '0;
        end
      end
    end else if (s1_go) begin
      win_r <= win_nxt;
    end
  end

  always_comb begin
    ctr    = win_nxt[1][1];
    hz_sum = {1'b0, win_nxt[1][0]} + {1'b0, win_nxt[1][2]};
    vt_sum = {1'b0, win_nxt[0][1]} + {1'b0, win_nxt[2][1]};
    dg_sum = {2'b00, win_nxt[0][0]} + {2'b00, win_nxt[0][2]} +
             {2'b00, win_nxt[2][0]} + {2'b00, win_nxt[2][2]};
    cr_sum = {1'b0, hz_sum} + {1'b0, vt_sum};

    red_nxt   = '0;
    green_nxt = '0;
    blue_nxt  = '0;
    if (!c1_r.border) begin
      if (c1_r.px && c1_r.py) begin
        red_nxt   = ctr;
        green_nxt = cr_sum[PB+1:2];
        blue_nxt  = dg_sum[PB+1:2];
      end else if (!c1_r.px && !c1_r.py) begin
        red_nxt   = dg_sum[PB+1:2];
        green_nxt = cr_sum[PB+1:2];
        blue_nxt  = ctr;
      end else if (!c1_r.px) begin
        red_nxt   = hz_sum[PB:1];
        green_nxt = ctr;
        blue_nxt  = vt_sum[PB:1];
      end else begin
        red_nxt   = vt_sum[PB:1];
        green_nxt = ctr;
        blue_nxt  = hz_sum[PB:1];
      end
    end
  end

  // ---------------- result register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go && c1_r.has_result) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && c1_r.has_result) begin
      red_r    <= PORT_PIX_W'(red_nxt);
      green_r  <= PORT_PIX_W'(green_nxt);
      blue_r   <= PORT_PIX_W'(blue_nxt);
      border_r <= c1_r.border;
      fend_r   <= c1_r.frame_end;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_red       = red_r;
  assign out_green     = green_r;
  assign out_blue      = blue_r;
  assign out_border    = border_r;
  assign out_frame_end = fend_r;

  // ---------------- assertions ----------------
  `BBD_ASSERT_IMP(a_stall_only_when_full, clk, rst_n, !in_ready, v1_r && out_valid_r)
  `BBD_ASSERT_NXT(a_s1_holds_on_stall, clk, rst_n,
                  v1_r && c1_r.has_result && out_valid_r && !out_ready, v1_r)
  `BBD_ASSERT_IMP(a_frame_end_is_border, clk, rst_n, out_valid && out_frame_end, out_border)
  `BBD_ASSERT_IMP(a_border_zero, clk, rst_n, out_valid && out_border,
                  out_red == '0 && out_green == '0 && out_blue == '0)

endmodule

// ----- dv/bayer_rgb_checker.sv -----
// ----------------------------------------------------------------------------
// bayer_rgb_checker
// Watches the pixel, RGB and register ports of the demosaic core. Keeps its
// own line stores, 3x3 window, raster position and register copies, works out
// the RGB result of every accepted pixel not in row 0 or column 0, and compares
// each accepted result, field by field, with the oldest one still waiting.
// ----------------------------------------------------------------------------
module bayer_rgb_checker
  import bbd_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic                   in_ready,
  input  logic [PORT_PIX_W-1:0]  in_raw_pixel,
  input  logic                   out_valid,
  input  logic                   out_ready,
  input  logic [PORT_PIX_W-1:0]  out_red,
  input  logic [PORT_PIX_W-1:0]  out_green,
  input  logic [PORT_PIX_W-1:0]  out_blue,
  input  logic                   out_border,
  input  logic                   out_frame_end,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  output int                     errors,
  output int                     results_pending,
  output logic                   frame_origin,
  output int                     pixels_seen,
  output int                     results_seen,
  output int                     interior_seen
);

  typedef struct packed {
    logic [PORT_PIX_W-1:0] red;
    logic [PORT_PIX_W-1:0] green;
    logic [PORT_PIX_W-1:0] blue;
    logic                  border;
    logic                  frame_end;
  } rgb_result_t;

  logic [WIDTH_REG_W-1:0]  width_reg;
  logic [HEIGHT_REG_W-1:0] height_reg;
  logic                    x_phase;
  logic                    y_phase;

  // row y-1 and row y-2
  logic [PORT_PIX_W-1:0] row_above [MAX_WIDTH_DEF];
  logic [PORT_PIX_W-1:0] row_above2 [MAX_WIDTH_DEF];
  logic [PORT_PIX_W-1:0] win [3][3];
  int                    col_pos;
  int                    row_pos;

  rgb_result_t rgb_expected [$];

  initial begin
    errors        = 0;
    pixels_seen   = 0;
    results_seen  = 0;
    interior_seen = 0;
  end

  task automatic demosaic_pixel(input logic [PORT_PIX_W-1:0] pix);
    int          w;
    int          h;
    int          xi;
    int          cx;
    int          cy;
    logic        last_col;
    logic        last_row;
    logic        px;
    logic        py;
    logic [17:0] hz;
    logic [17:0] vt;
    logic [17:0] dg;
    logic [17:0] cr;
    rgb_result_t res;
    w = width_reg;
    if (w < DIM_MIN) w = DIM_MIN;
    else if (w > MAX_WIDTH_DEF) w = MAX_WIDTH_DEF;
    h = height_reg;
    if (h < DIM_MIN) h = DIM_MIN;
    else if (h > MAX_HEIGHT_DEF) h = MAX_HEIGHT_DEF;
    xi = col_pos % MAX_WIDTH_DEF;
    // a position past a shrunken size counts as the last one
    last_col = col_pos >= w - 1;
    last_row = row_pos >= h - 1;

    for (int r = 0; r < 3; r++) begin
      win[r][0] = win[r][1];
      win[r][1] = win[r][2];
    end
    win[0][2] = row_above2[xi];
    win[1][2] = row_above[xi];
    win[2][2] = pix;
    row_above2[xi] = row_above[xi];
    row_above[xi]  = pix;

    if (col_pos >= 1 && row_pos >= 1) begin
      cx = col_pos - 1;
      cy = row_pos - 1;
      res = '0;
      res.border = cx < 2 || cx >= w - 2 || cy < 2 || cy >= h - 2;
      if (!res.border) begin
        px = cx[0] ^ x_phase;
        py = cy[0] ^ y_phase;
        // sums carry two extra bits so four full-scale samples fit
        hz = ({2'b00, win[1][0]} + {2'b00, win[1][2]}) >> 1;
        vt = ({2'b00, win[0][1]} + {2'b00, win[2][1]}) >> 1;
        dg = ({2'b00, win[0][0]} + {2'b00, win[0][2]} + {2'b00, win[2][0]}
              + {2'b00, win[2][2]}) >> 2;
        cr = ({2'b00, win[1][0]} + {2'b00, win[1][2]} + {2'b00, win[0][1]}
              + {2'b00, win[2][1]}) >> 2;
        case ({px, py})
          2'b11: begin
            res.red   = win[1][1];
            res.green = cr[PORT_PIX_W-1:0];
            res.blue  = dg[PORT_PIX_W-1:0];
          end
          2'b00: begin
            res.red   = dg[PORT_PIX_W-1:0];
            res.green = cr[PORT_PIX_W-1:0];
            res.blue  = win[1][1];
          end
          2'b01: begin
            res.red   = hz[PORT_PIX_W-1:0];
            res.green = win[1][1];
            res.blue  = vt[PORT_PIX_W-1:0];
          end
          default: begin
            res.red   = vt[PORT_PIX_W-1:0];
            res.green = win[1][1];
            res.blue  = hz[PORT_PIX_W-1:0];
          end
        endcase
      end
      res.frame_end = last_col && last_row;
      rgb_expected.push_back(res);
    end

    if (last_col) begin
      col_pos = 0;
      row_pos = last_row ? 0 : row_pos + 1;
    end else begin
      col_pos = col_pos + 1;
    end
  endtask

  task automatic check_field(input string name, input logic [PORT_PIX_W-1:0] want,
                             input logic [PORT_PIX_W-1:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    rgb_result_t want;
    if (!rst_n) begin
      width_reg  = WIDTH_RST;
      height_reg = HEIGHT_RST;
      x_phase    = 1'b0;
      y_phase    = 1'b0;
      for (int i = 0; i < MAX_WIDTH_DEF; i++) begin
        row_above[i]  = '0;
        row_above2[i] = '0;
      end
      for (int r = 0; r < 3; r++)
        for (int c = 0; c < 3; c++)
          win[r][c] = '0;
      col_pos = 0;
      row_pos = 0;
      rgb_expected.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_WIDTH:   width_reg  = cfg_wdata[WIDTH_REG_W-1:0];
          REG_HEIGHT:  height_reg = cfg_wdata[HEIGHT_REG_W-1:0];
          REG_X_PHASE: x_phase    = cfg_wdata[0];
          REG_Y_PHASE: y_phase    = cfg_wdata[0];
          default: ;
        endcase
      end
      // retire before predicting so a result cannot match its own item
      if (out_valid && out_ready) begin
        results_seen++;
        if (rgb_expected.size() == 0) begin
          $error("RGB result with no pixel waiting for one");
          errors++;
        end else begin
          want = rgb_expected.pop_front();
          if (!want.border) interior_seen++;
          check_field("red", want.red, out_red);
          check_field("green", want.green, out_green);
          check_field("blue", want.blue, out_blue);
          check_field("border", PORT_PIX_W'(want.border), PORT_PIX_W'(out_border));
          check_field("frame_end", PORT_PIX_W'(want.frame_end),
                      PORT_PIX_W'(out_frame_end));
        end
      end
      if (in_valid && in_ready) begin
        pixels_seen++;
        demosaic_pixel(in_raw_pixel);
      end
    end
    results_pending = rgb_expected.size();
    frame_origin    = col_pos == 0 && row_pos == 0;
  end

endmodule

// ----- dv/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Streams raw Bayer frames into the demosaic core: a short frame of extreme
// samples, a long row at the widest clamped size cut short by a width shrink,
// a frame at the tallest clamped size, then many small frames with random
// sizes, filter phases and mid-frame changes.
// Both handshakes idle at random; the checker beside the core scores results.
// ----------------------------------------------------------------------------
module testbench;
  import bbd_pkg::*;

  localparam int TIMEOUT_TIME   = 2_000_000;
  localparam int SETTLE_CYCLES  = 4;
  localparam int WIDE_PIXELS    = 300;
  localparam int RANDOM_PIXELS  = 1500;
  localparam int CALM_FIRST     = 1000;
  localparam int CALM_LAST      = 1400;
  localparam int FIRST_SPARE_REG = REG_Y_PHASE + 1;
  localparam int LAST_SPARE_REG  = (1 << CFG_INDEX_W) - 1;

  logic                   clk;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [PORT_PIX_W-1:0]  in_raw_pixel = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [PORT_PIX_W-1:0]  out_red;
  logic [PORT_PIX_W-1:0]  out_green;
  logic [PORT_PIX_W-1:0]  out_blue;
  logic                   out_border;
  logic                   out_frame_end;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

  int   errors;
  int   results_pending;
  logic frame_origin;
  int   pixels_seen;
  int   results_seen;
  int   interior_seen;

  int   pixels_sent = 0;
  int   frames_sent = 0;
  int   cur_w;
  int   cur_h;
  logic no_gaps = 1'b0;

  bayer_bilinear_demosaic_core dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_raw_pixel  (in_raw_pixel),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_red       (out_red),
    .out_green     (out_green),
    .out_blue      (out_blue),
    .out_border    (out_border),
    .out_frame_end (out_frame_end),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  bayer_rgb_checker rgb_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_raw_pixel    (in_raw_pixel),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_red         (out_red),
    .out_green       (out_green),
    .out_blue        (out_blue),
    .out_border      (out_border),
    .out_frame_end   (out_frame_end),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .errors          (errors),
    .results_pending (results_pending),
    .frame_origin    (frame_origin),
    .pixels_seen     (pixels_seen),
    .results_seen    (results_seen),
    .interior_seen   (interior_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(TIMEOUT_TIME);
    $display("Timed out with %0d results still pending", results_pending);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  always @(negedge clk) begin
    out_ready <= no_gaps || $urandom_range(99) >= 10;
  end

  function automatic logic [PORT_PIX_W-1:0] raw_sample();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      2: return PORT_PIX_W'(16'hFFFF - $urandom_range(15));
      default: return PORT_PIX_W'($urandom_range(16'hFFFF));
    endcase
  endfunction

  // entered and left at a falling edge; valid stays up into the next item
  task automatic send_pixel(input logic [PORT_PIX_W-1:0] pix);
    no_gaps <= pixels_sent >= CALM_FIRST && pixels_sent < CALM_LAST;
    while (!no_gaps && $urandom_range(99) < 10) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_raw_pixel <= pix;
    do @(posedge clk); while (!in_ready);
    pixels_sent++;
    @(negedge clk);
  endtask

  // let the core drain before a register write; a pixel at column 0 or
  // row 0 leaves nothing to wait for, hence the extra cycles
  task automatic settle();
    in_valid <= 1'b0;
    while (results_pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic finish_frame();
    do send_pixel(raw_sample()); while (!frame_origin);
    frames_sent++;
  endtask

  initial begin
    int                    start_pixels;
    int                    wreg;
    int                    hreg;
    int                    k;
    logic [CFG_DATA_W-1:0] data;
    logic [PORT_PIX_W-1:0] pattern [6];

    pattern = '{16'h0000, 16'hFFFF, 16'hFFFF, 16'h8000, 16'hFFFF, 16'h0001};
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // 6 wide, height below range clamps to 5; full-scale sums in the window
    write_reg(REG_WIDTH, 13'd6);
    write_reg(REG_HEIGHT, 13'd0);
    write_reg(REG_X_PHASE, 13'd1);
    write_reg(REG_Y_PHASE, 13'd0);
    write_reg(CFG_INDEX_W'(LAST_SPARE_REG), '1);
    for (int i = 0; i < 30; i++) send_pixel(pattern[i % 6]);
    frames_sent++;

    // widest clamped width, then a mid-frame shrink wraps the long row
    settle();
    write_reg(REG_WIDTH, 13'h0FFF);
    write_reg(REG_HEIGHT, 13'd5);
    for (int i = 0; i < WIDE_PIXELS; i++) send_pixel(raw_sample());
    settle();
    write_reg(REG_WIDTH, 13'd8);
    finish_frame();

    // tallest clamped frame, cut short while past the new last row
    settle();
    write_reg(REG_WIDTH, 13'h1005);
    write_reg(REG_HEIGHT, 13'h1FFF);
    write_reg(REG_Y_PHASE, 13'd1);
    for (int i = 0; i < 32; i++) send_pixel(raw_sample());
    settle();
    write_reg(REG_HEIGHT, 13'd5);
    finish_frame();
    cur_w = 5;
    cur_h = 5;

    start_pixels = pixels_sent;
    while (pixels_sent - start_pixels < RANDOM_PIXELS) begin
      settle();
      wreg = ($urandom_range(15) == 0) ? $urandom_range(DIM_MIN - 1, 0)
                                       : $urandom_range(12, DIM_MIN);
      hreg = ($urandom_range(15) == 0) ? $urandom_range(DIM_MIN - 1, 0)
                                       : $urandom_range(10, DIM_MIN);
      if ($urandom_range(3) != 0) begin
        data = CFG_DATA_W'(wreg);
        data[WIDTH_REG_W] = 1'($urandom_range(1));
        write_reg(REG_WIDTH, data);
        cur_w = (wreg < DIM_MIN) ? DIM_MIN : wreg;
      end
      if ($urandom_range(3) != 0) begin
        write_reg(REG_HEIGHT, CFG_DATA_W'(hreg));
        cur_h = (hreg < DIM_MIN) ? DIM_MIN : hreg;
      end
      if ($urandom_range(1)) write_reg(REG_X_PHASE, CFG_DATA_W'($urandom));
      if ($urandom_range(1)) write_reg(REG_Y_PHASE, CFG_DATA_W'($urandom));
      if ($urandom_range(7) == 0)
        write_reg(CFG_INDEX_W'($urandom_range(LAST_SPARE_REG, FIRST_SPARE_REG)),
                  CFG_DATA_W'($urandom));

      // mid-frame change: width may only shrink, height and x phase may move
      if ($urandom_range(3) == 0) begin
        k = $urandom_range(cur_w * cur_h - 1, 1);
        for (int i = 0; i < k; i++) send_pixel(raw_sample());
        settle();
        cur_w = $urandom_range(cur_w, DIM_MIN);
        cur_h = $urandom_range(12, DIM_MIN);
        write_reg(REG_WIDTH, CFG_DATA_W'(cur_w));
        write_reg(REG_HEIGHT, CFG_DATA_W'(cur_h));
        write_reg(REG_X_PHASE, CFG_DATA_W'($urandom));
      end
      finish_frame();
    end

    settle();
    repeat (8) @(negedge clk);
    $display("Summary: %0d pixels in %0d frames, %0d RGB results checked",
             pixels_seen, frames_sent, results_seen);
    $display("  %0d interior results, %0d border results",
             interior_seen, results_seen - interior_seen);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- bayer_bilinear_demosaic_core.f -----
+incdir+rtl/core
rtl/core/bbd_pkg.sv
rtl/core/bbd_ram.sv
rtl/core/bayer_bilinear_demosaic_core.sv
dv/bayer_rgb_checker.sv
dv/testbench.sv
